>>> rtl/irlex_pkg.sv
// Shared types, character codes and decode functions for the IR token lexer.
package irlex_pkg;

  localparam int unsigned DefQueueDepth = 4;

  typedef enum logic [3:0] {
    TK_OPEN     = 4'd0,
    TK_CLOSE    = 4'd1,
    TK_VAR      = 4'd2,
    TK_TYPE     = 4'd3,
    TK_FUNC     = 4'd4,
    TK_INT      = 4'd5,
    TK_UNSIGNED = 4'd6,
    TK_REAL     = 4'd7,
    TK_OPCODE   = 4'd8,
    TK_BITSET   = 4'd9,
    TK_HOLE     = 4'd10,
    TK_NULL     = 4'd11,
    TK_SCHAR    = 4'd12,
    TK_SEND     = 4'd13,
    TK_ERROR    = 4'd14
  } tok_kind_e;

  // Character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChBel    = 8'h07;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0a;
  localparam logic [7:0] ChVt     = 8'h0b;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChDash   = 8'h2d;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoB    = 8'h62;
  localparam logic [7:0] ChLoF    = 8'h66;
  localparam logic [7:0] ChLoI    = 8'h69;
  localparam logic [7:0] ChLoN    = 8'h6e;
  localparam logic [7:0] ChLoR    = 8'h72;
  localparam logic [7:0] ChLoT    = 8'h74;
  localparam logic [7:0] ChLoU    = 8'h75;
  localparam logic [7:0] ChLoV    = 8'h76;
  localparam logic [7:0] ChLoX    = 8'h78;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [63:0] token_value;
    logic        last_of_run;
  } tok_t;

  // One queue entry: every token caused by one byte
  typedef struct packed {
    logic second;
    tok_t tok0;
    tok_t tok1;
  } entry_t;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
      return {1'b1, d[3:0]};
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = c - ChUpA + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= ChLoA && c <= ChLoF) begin
      d = c - ChLoA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // TK_OPEN means the byte is no number prefix
  function automatic tok_kind_e prefix_kind(logic [7:0] c);
    unique case (c)
      ChLoV:   return TK_VAR;
      ChLoT:   return TK_TYPE;
      ChLoF:   return TK_FUNC;
      ChLoI:   return TK_INT;
      ChLoU:   return TK_UNSIGNED;
      ChLoR:   return TK_REAL;
      ChLoX:   return TK_OPCODE;
      default: return TK_OPEN;
    endcase
  endfunction

  // {valid, decoded character}
  function automatic logic [8:0] esc_decode(logic [7:0] c);
    unique case (c)
      ChLoN:    return {1'b1, ChNl};
      ChLoV:    return {1'b1, ChVt};
      ChLoT:    return {1'b1, ChTab};
      ChLoR:    return {1'b1, ChCr};
      ChBslash: return {1'b1, ChBslash};
      ChSquote: return {1'b1, ChSquote};
      ChDquote: return {1'b1, ChDquote};
      ChZero:   return {1'b1, ChNul};
      ChLoA:    return {1'b1, ChBel};
      default:  return 9'd0;
    endcase
  endfunction

endpackage

>>> rtl/irlex_front.sv
// Lexer front end: takes one byte per transfer, updates the mode and builds its tokens.
module irlex_front import irlex_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output entry_t   entry_o
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_NUMBER,
    M_BITSET,
    M_COMMENT,
    M_STRING,
    M_ESCAPE,
    M_ENDED
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [63:0] acc_q, acc_d;
  tok_kind_e   pkind_q, pkind_d;

  logic        accept;
  logic [7:0]  c;
  logic [4:0]  hex;
  logic [8:0]  esc;

  // byte as lexed between tokens
  tok_kind_e   idle_pkind;
  mode_e       idle_mode;
  logic        idle_emit;
  tok_kind_e   idle_kind;
  logic [63:0] idle_val;

  logic        emit_a, emit_b, emit_c, run_idle;
  tok_t        tok_a, tok_b, tok_c;
  logic [1:0]  cnt;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign c          = in_data_i.text_byte;
  assign hex        = hex_digit(c);
  assign esc        = esc_decode(c);
  assign idle_pkind = prefix_kind(c);

  always_comb begin
    idle_mode = M_IDLE;
    idle_emit = 1'b0;
    idle_kind = TK_ERROR;
    idle_val  = 64'd0;
    if (idle_pkind != TK_OPEN) begin
      idle_mode = M_NUMBER;
    end else begin
      unique case (c)
        ChLparen: begin
          idle_emit = 1'b1;
          idle_kind = TK_OPEN;
        end
        ChRparen: begin
          idle_emit = 1'b1;
          idle_kind = TK_CLOSE;
        end
        ChUnder: begin
          idle_emit = 1'b1;
          idle_kind = TK_HOLE;
        end
        ChDash: begin
          idle_emit = 1'b1;
          idle_kind = TK_NULL;
        end
        ChLoB:   idle_mode = M_BITSET;
        ChSemi:  idle_mode = M_COMMENT;
        ChDquote: idle_mode = M_STRING;
        ChSpace, ChTab, ChVt, ChNl: idle_mode = M_IDLE;
        ChNul:   idle_mode = M_ENDED;
        default: begin
          idle_emit = 1'b1;
          idle_kind = TK_ERROR;
          idle_val  = {56'd0, c};
        end
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    pkind_d  = pkind_q;
    emit_a   = 1'b0;
    emit_c   = 1'b0;
    run_idle = 1'b0;
    tok_a    = '{token_kind: TK_ERROR, token_value: 64'd0, last_of_run: 1'b0};
    tok_c    = '{token_kind: TK_ERROR, token_value: 64'd0, last_of_run: 1'b0};

    unique case (mode_q)
      M_NUMBER: begin
        if (hex[4]) begin
          acc_d = {acc_q[59:0], hex[3:0]};
        end else begin
          emit_a   = 1'b1;
          tok_a    = '{token_kind: pkind_q, token_value: acc_q, last_of_run: 1'b0};
          run_idle = 1'b1;
        end
      end
      M_BITSET: begin
        if (c == ChHash || c == ChUnder) begin
          acc_d = {acc_q[62:0], c == ChHash};
        end else begin
          emit_a   = 1'b1;
          tok_a    = '{token_kind: TK_BITSET, token_value: acc_q, last_of_run: 1'b0};
          run_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == ChNl) mode_d = M_IDLE;
      end
      M_STRING: begin
        if (c == ChBslash) begin
          mode_d = M_ESCAPE;
        end else if (c == ChDquote) begin
          emit_a = 1'b1;
          tok_a  = '{token_kind: TK_SEND, token_value: 64'd0, last_of_run: 1'b0};
          mode_d = M_IDLE;
        end else begin
          emit_a = 1'b1;
          tok_a  = '{token_kind: TK_SCHAR, token_value: {56'd0, c}, last_of_run: 1'b0};
        end
      end
      M_ESCAPE: begin
        emit_a = 1'b1;
        if (esc[8]) begin
          tok_a  = '{token_kind: TK_SCHAR, token_value: {56'd0, esc[7:0]},
                     last_of_run: 1'b0};
          mode_d = M_STRING;
        end else begin
          tok_a  = '{token_kind: TK_ERROR, token_value: {56'd0, c}, last_of_run: 1'b0};
          mode_d = M_IDLE;
        end
      end
      M_ENDED: mode_d = M_ENDED;
      default: run_idle = 1'b1;
    endcase

    // a terminating byte is lexed again as if between tokens
    emit_b = run_idle && idle_emit;
    tok_b  = '{token_kind: idle_kind, token_value: idle_val, last_of_run: 1'b0};
    if (run_idle) begin
      mode_d = idle_mode;
      if (idle_mode == M_NUMBER) begin
        pkind_d = idle_pkind;
        acc_d   = 64'd0;
      end else if (idle_mode == M_BITSET) begin
        acc_d = 64'd0;
      end
    end

    if (in_data_i.end_of_text) begin
      unique case (mode_d)
        M_NUMBER: begin
          emit_c = 1'b1;
          tok_c  = '{token_kind: pkind_d, token_value: acc_d, last_of_run: 1'b0};
        end
        M_BITSET: begin
          emit_c = 1'b1;
          tok_c  = '{token_kind: TK_BITSET, token_value: acc_d, last_of_run: 1'b0};
        end
        M_STRING: begin
          emit_c = 1'b1;
          tok_c  = '{token_kind: TK_SEND, token_value: 64'd0, last_of_run: 1'b0};
        end
        M_ESCAPE: begin
          emit_c = 1'b1;
          tok_c  = '{token_kind: TK_ERROR, token_value: 64'd0, last_of_run: 1'b0};
        end
        default: emit_c = 1'b0;
      endcase
      mode_d = M_IDLE;
    end
  end

  // at most two of the three candidates fire for one byte
  always_comb begin
    cnt = {1'b0, emit_a} + {1'b0, emit_b} + {1'b0, emit_c};
    entry_o.second = (cnt == 2'd2);
    entry_o.tok0   = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    entry_o.tok1   = (emit_a && emit_b) ? tok_b : tok_c;
    entry_o.tok0.last_of_run = (cnt == 2'd1);
    entry_o.tok1.last_of_run = 1'b1;
    push_o = accept && (cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= 64'd0;
      pkind_q <= TK_OPEN;
    end else if (accept) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      pkind_q <= pkind_d;
    end
  end

`ifndef SYNTHESIS
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_text |=> mode_q == M_IDLE)
    else $error("lexer not idle after end of text");

  a_ended_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_ENDED && !in_data_i.end_of_text |-> !push_o)
    else $error("token produced after zero byte");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept && !full_i)
    else $error("queue push without transfer");
`endif

endmodule

>>> rtl/irlex_queue.sv
// Short token-bundle queue between the lexer front end and the output stage.
module irlex_queue import irlex_pkg::*; #(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count out of range");
`endif

endmodule

>>> rtl/irlex_back.sv
// Output stage: unpacks queued bundles into single token transfers.
module irlex_back import irlex_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   empty_i,
  input  entry_t entry_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output tok_t   out_data_o
);

  logic out_valid_q;
  tok_t out_q;
  logic sec_valid_q;
  tok_t sec_q;
  logic load;

  assign load        = !out_valid_q || !out_stall_i;
  assign pop_o       = load && !sec_valid_q && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        out_valid_q <= !empty_i;
        sec_valid_q <= !empty_i && entry_i.second;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_valid_q) begin
        out_q <= sec_q;
      end else begin
        out_q <= entry_i.tok0;
        sec_q <= entry_i.tok1;
      end
    end
  end

`ifndef SYNTHESIS
  a_second_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> out_valid_q && !out_q.last_of_run)
    else $error("second token held without its first on the port");

  a_first_has_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last_of_run |-> sec_valid_q)
    else $error("non-final token without a following token");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !sec_valid_q)
    else $error("bundle popped while second token pending");
`endif

endmodule

>>> rtl/ir_token_lexer_core.sv
// Top level of the IR token lexer: front end, bundle queue and output stage.
// Each token is written into the queue, then registered in the output stage.
// Throughput: one byte per cycle while the queue is not full and each byte gives
//   at most one token; a byte's two tokens share the single output port via the queue.
// Reset: asynchronous; lexer idle with zero accumulator, queue empty, output invalid.
module ir_token_lexer_core import irlex_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tok_t     out_data_o
);

  logic   full, empty, push, pop;
  entry_t push_data, pop_data;

  irlex_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_data)
  );

  irlex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  irlex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the IR token lexer: directed and random byte streams.
`timescale 1ns / 100ps

module testbench;
  import irlex_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int PhaseItems    = 584;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_NUMBER,
    LX_BITSET,
    LX_COMMENT,
    LX_STRING,
    LX_ESCAPE,
    LX_ENDED
  } lex_mode_e;

  // Tracks the lexer state, predicts tokens per byte and checks them in order
  class lex_scoreboard;
    lex_mode_e mode;
    logic [63:0] acc;
    tok_kind_e num_kind;
    tok_t tokens_due[$];
    int n_faults;

    function new();
      mode = LX_IDLE;
      acc = '0;
      num_kind = TK_OPEN;
      n_faults = 0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function void emit(tok_kind_e k, logic [63:0] v);
      tok_t t;
      t.token_kind = k;
      t.token_value = v;
      t.last_of_run = 1'b0;
      tokens_due.push_back(t);
    endfunction

    function bit hex_nibble(input logic [7:0] c, output logic [3:0] d);
      logic [7:0] t;
      t = 8'd0;
      d = 4'd0;
      if (c >= ChZero && c <= ChNine) t = c - ChZero;
      else if (c >= ChUpA && c <= ChUpF) t = c - ChUpA + 8'd10;
      else if (c >= ChLoA && c <= ChLoF) t = c - ChLoA + 8'd10;
      else return 1'b0;
      d = t[3:0];
      return 1'b1;
    endfunction

    function bit num_prefix(input logic [7:0] c, output tok_kind_e k);
      k = TK_OPEN;
      case (c)
        ChLoV: k = TK_VAR;
        ChLoT: k = TK_TYPE;
        ChLoF: k = TK_FUNC;
        ChLoI: k = TK_INT;
        ChLoU: k = TK_UNSIGNED;
        ChLoR: k = TK_REAL;
        ChLoX: k = TK_OPCODE;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function bit unescape(input logic [7:0] c, output logic [7:0] d);
      d = 8'd0;
      case (c)
        ChLoN: d = ChNl;
        ChLoV: d = ChVt;
        ChLoT: d = ChTab;
        ChLoR: d = ChCr;
        ChBslash: d = ChBslash;
        ChSquote: d = ChSquote;
        ChDquote: d = ChDquote;
        ChZero: d = ChNul;
        ChLoA: d = ChBel;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void lex_idle(logic [7:0] c);
      tok_kind_e k;
      if (num_prefix(c, k)) begin
        mode = LX_NUMBER;
        num_kind = k;
        acc = '0;
        return;
      end
      case (c)
        ChLparen: emit(TK_OPEN, '0);
        ChRparen: emit(TK_CLOSE, '0);
        ChUnder: emit(TK_HOLE, '0);
        ChDash: emit(TK_NULL, '0);
        ChLoB: begin
          mode = LX_BITSET;
          acc = '0;
        end
        ChSemi: mode = LX_COMMENT;
        ChDquote: mode = LX_STRING;
        ChSpace, ChTab, ChVt, ChNl: ;
        ChNul: mode = LX_ENDED;
        default: emit(TK_ERROR, {56'd0, c});
      endcase
    endfunction

    // Called on every input transfer
    function void note_input(in_item_t it);
      logic [7:0] c;
      logic [3:0] nib;
      logic [7:0] ch;
      tok_t t;
      int n0;
      c = it.text_byte;
      n0 = tokens_due.size();
      case (mode)
        LX_NUMBER: begin
          if (hex_nibble(c, nib)) acc = {acc[59:0], nib};
          else begin
            emit(num_kind, acc);
            mode = LX_IDLE;
            lex_idle(c);
          end
        end
        LX_BITSET: begin
          if (c == ChHash || c == ChUnder) acc = {acc[62:0], c == ChHash};
          else begin
            emit(TK_BITSET, acc);
            mode = LX_IDLE;
            lex_idle(c);
          end
        end
        LX_COMMENT: if (c == ChNl) mode = LX_IDLE;
        LX_STRING: begin
          if (c == ChBslash) mode = LX_ESCAPE;
          else if (c == ChDquote) begin
            emit(TK_SEND, '0);
            mode = LX_IDLE;
          end else emit(TK_SCHAR, {56'd0, c});
        end
        LX_ESCAPE: begin
          if (unescape(c, ch)) begin
            emit(TK_SCHAR, {56'd0, ch});
            mode = LX_STRING;
          end else begin
            emit(TK_ERROR, {56'd0, c});
            mode = LX_IDLE;
          end
        end
        LX_ENDED: ;
        default: lex_idle(c);
      endcase
      // end of text flushes whatever token is still open
      if (it.end_of_text) begin
        case (mode)
          LX_NUMBER: emit(num_kind, acc);
          LX_BITSET: emit(TK_BITSET, acc);
          LX_STRING: emit(TK_SEND, '0);
          LX_ESCAPE: emit(TK_ERROR, '0);
          default: ;
        endcase
        mode = LX_IDLE;
      end
      if (tokens_due.size() > n0) begin
        t = tokens_due.pop_back();
        t.last_of_run = 1'b1;
        tokens_due.push_back(t);
      end
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (tokens_due.size() == 0) begin
        $error("token_kind: expected none, actual %0d (value %h)",
               got.token_kind, got.token_value);
        n_faults++;
        return;
      end
      want = tokens_due.pop_front();
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, actual %0d", want.token_kind, got.token_kind);
        n_faults++;
      end
      if (got.token_value !== want.token_value) begin
        $error("token_value: expected %h, actual %h", want.token_value, got.token_value);
        n_faults++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
        n_faults++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tok_t out_data_o;

  lex_scoreboard sb;
  int send_idle = 27;
  int recv_idle = 84;
  int n_sent = 0;
  int quiet_cycles = 0;

  localparam logic [7:0] PrefixChars [7] = '{ChLoV, ChLoT, ChLoF, ChLoI, ChLoU, ChLoR, ChLoX};
  localparam logic [7:0] EscChars [9] =
    '{ChLoN, ChLoV, ChLoT, ChLoR, ChBslash, ChSquote, ChDquote, ChZero, ChLoA};
  localparam logic [7:0] LoneChars [8] =
    '{ChLparen, ChRparen, ChUnder, ChDash, ChSpace, ChTab, ChVt, ChNl};

  ir_token_lexer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Output side: check transfers, random stall, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_token(out_data_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle);
  end

  task automatic send_item(input logic [7:0] c, input logic eot);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.text_byte <= c;
    in_data_i.end_of_text <= eot;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(in_data_i);
    n_sent++;
  endtask

  // Random end-of-text marks on a few bytes
  task automatic send_char(input logic [7:0] c);
    send_item(c, $urandom_range(0, 49) == 0);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], eot_last && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_lexeme();
    int sel;
    int n;
    logic [3:0] nib;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      send_char(PrefixChars[$urandom_range(0, 6)]);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 6);
      repeat (n) begin
        nib = 4'($urandom_range(0, 15));
        if (nib < 10) c = ChZero + nib;
        else if ($urandom_range(0, 1)) c = ChUpA + nib - 4'd10;
        else c = ChLoA + nib - 4'd10;
        send_char(c);
      end
    end else if (sel < 45) begin
      send_char(ChLoB);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
      repeat (n) send_char($urandom_range(0, 1) ? ChHash : ChUnder);
    end else if (sel < 60) begin
      send_char(ChDquote);
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_char(ChBslash);
          if ($urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)));
          else send_char(EscChars[$urandom_range(0, 8)]);
        end else send_char(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) != 0) send_char(ChDquote);
    end else if (sel < 68) begin
      send_char(ChSemi);
      repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(0, 255)));
      send_char(ChNl);
    end else if (sel < 88) begin
      send_char(LoneChars[$urandom_range(0, 7)]);
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int start;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: many token kinds, two tokens from one byte, flushes at end of text
    send_text("(xA_-)", 1'b0);
    send_text("b#_#;c\n", 1'b0);
    send_text("\"a\\n\\q", 1'b0);
    send_item(ChCr, 1'b0);
    send_item(8'hff, 1'b0);
    send_text("u1F", 1'b1);
    send_text("\"\\", 1'b1);
    send_item(ChNul, 1'b0);
    send_text("((", 1'b1);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 27; recv_idle = 84; end
        1: begin send_idle = 84; recv_idle = 27; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      start = n_sent;
      while (n_sent - start < PhaseItems) send_lexeme();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (sb.n_faults == 0 && sb.pending() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/irlex_pkg.sv
rtl/irlex_front.sv
rtl/irlex_queue.sv
rtl/irlex_back.sv
rtl/ir_token_lexer_core.sv
verif/testbench.sv
